@@ rtl/hee_pkg.sv @@
// Shared constants, types and operation codes of the histogram equalization engine.
package hee_pkg;

   localparam int BIN_COUNT  = 256;
   localparam int COUNT_BITS = 20;
   localparam int ADDR_BITS  = $clog2(BIN_COUNT);
   localparam int GRAY_BITS  = 8;
   localparam int CDF_BITS   = COUNT_BITS + ADDR_BITS;
   localparam int STEP_BITS  = $clog2(GRAY_BITS);

   localparam logic [GRAY_BITS-1:0] GRAY_MAX = {GRAY_BITS{1'b1}};

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [GRAY_BITS-1:0]  gray_type;
   typedef logic [CDF_BITS-1:0]   cdf_type;
   typedef logic [STEP_BITS-1:0]  step_type;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_COUNT = 2'd1,
      FUNC_BUILD = 2'd2,
      FUNC_MAP   = 2'd3
   } func_type;

   // One write into the bin memory
   typedef struct packed {
      logic      en;
      addr_type  addr;
      count_type data;
   } ram_wr_type;

endpackage

@@ rtl/histogram_equalization_engine_top.sv @@
// Histogram equalization engine: top level with item pipeline and map-build sequencer.
//
// Clear, count and map items are taken one per cycle while intake does not stall: the
// bin memory is read in the cycle an item is accepted and written back in the next, with
// the last write forwarded when two items touch the same bin. A map item yields one
// result, held in an output register that lets the next item in while that result waits.
// A build item stops intake while the sequencer walks the 256 bins in order, each bin
// taking a memory read, an accumulate, a check and, when the quotient is below 255, a
// divide by the bit-serial divider. Build on an empty histogram or on an existing map is
// fast or ignored. Bins and the pixel total saturate at 2^20-1. No clearing pass follows
// reset.
module histogram_equalization_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  hee_pkg::func_type  req_func,
   input  hee_pkg::gray_type  req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hee_pkg::gray_type  rsp_mapped_pixel,
   output logic               rsp_not_ready
);
   import hee_pkg::*;

   typedef enum logic [4:0] {
      ST_RUN = 5'b00001,
      ST_RD  = 5'b00010,
      ST_ACC = 5'b00100,
      ST_CHK = 5'b01000,
      ST_DIV = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic       s1_valid_ff, s1_valid_in;
   func_type   s1_func_ff;
   gray_type   s1_pixel_ff;
   count_type  total_ff, total_in;
   logic       map_ready_ff, map_ready_in;
   addr_type   walk_ff, walk_in;
   cdf_type    cdf_ff, cdf_in;
   logic       fwd_valid_ff;
   addr_type   fwd_addr_ff;
   count_type  fwd_data_ff;
   logic       rsp_valid_ff;
   gray_type   rsp_pixel_ff;
   logic       rsp_flag_ff;

   logic       accept;
   logic       s1_go;
   logic       exec_clear;
   logic       exec_map;
   ram_wr_type ram_wr;
   logic       ram_rd_en;
   addr_type   ram_rd_addr;
   count_type  ram_rd_data;
   addr_type   data_addr;
   count_type  bin_data;
   logic       div_start;
   logic       div_done;
   gray_type   div_quotient;
   cdf_type    div_dividend;

   // Intake: stall behind a build, a walk, or a map result that cannot leave
   assign s1_go     = s1_valid_ff &&
                      !(s1_func_ff == FUNC_MAP && rsp_valid_ff && !rsp_ready);
   assign req_ready = (state_ff == ST_RUN) &&
                      !(s1_valid_ff && s1_func_ff == FUNC_BUILD) &&
                      (!s1_valid_ff || s1_go);
   assign accept    = req_valid && req_ready;

   assign exec_clear = s1_go && s1_func_ff == FUNC_CLEAR;
   assign exec_map   = s1_go && s1_func_ff == FUNC_MAP;

   // Memory read port: pixel on intake, walk index during build
   assign ram_rd_en   = accept || (state_ff == ST_RD);
   assign ram_rd_addr = (state_ff == ST_RD) ? walk_ff : req_pixel;

   // Forward the latest write over stale read data
   assign data_addr = (state_ff == ST_RUN) ? s1_pixel_ff : walk_ff;
   assign bin_data  = (fwd_valid_ff && fwd_addr_ff == data_addr) ? fwd_data_ff : ram_rd_data;

   assign div_dividend = (cdf_ff << GRAY_BITS) - cdf_ff;

   // Execute items and step the build walk
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      map_ready_in = map_ready_ff;
      walk_in      = walk_ff;
      cdf_in       = cdf_ff;
      ram_wr       = '0;
      div_start    = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (s1_go) begin
               case (s1_func_ff)
                  FUNC_CLEAR: begin
                     total_in     = '0;
                     map_ready_in = 1'b0;
                  end
                  FUNC_COUNT: begin
                     if (!map_ready_ff) begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = s1_pixel_ff;
                        ram_wr.data = (&bin_data) ? bin_data : bin_data + 1'b1;
                        total_in    = (&total_ff) ? total_ff : total_ff + 1'b1;
                     end
                  end
                  FUNC_BUILD: begin
                     if (!map_ready_ff) begin
                        state_in = ST_RD;
                        walk_in  = '0;
                        cdf_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cdf_in   = cdf_ff + cdf_type'(bin_data);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (total_ff == '0 || cdf_ff >= cdf_type'(total_ff)) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = walk_ff;
               ram_wr.data = (total_ff == '0) ? '0 : count_type'(GRAY_MAX);
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = walk_ff;
               ram_wr.data = count_type'(div_quotient);
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      // Advance the walk after each bin write, finish after the last bin
      if (state_ff != ST_RUN && ram_wr.en) begin
         if (walk_ff == addr_type'(BIN_COUNT - 1)) begin
            state_in     = ST_RUN;
            map_ready_in = 1'b1;
         end else begin
            walk_in  = walk_ff + 1'b1;
            state_in = ST_RD;
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         s1_valid_ff  <= 1'b0;
         total_ff     <= '0;
         map_ready_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         total_ff     <= total_in;
         map_ready_ff <= map_ready_in;
         if (exec_clear) begin
            fwd_valid_ff <= 1'b0;
         end else if (ram_wr.en) begin
            fwd_valid_ff <= 1'b1;
         end
         if (exec_map) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: accepted item, walk registers, last write, result
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= req_func;
         s1_pixel_ff <= req_pixel;
      end
      walk_ff <= walk_in;
      cdf_ff  <= cdf_in;
      if (ram_wr.en) begin
         fwd_addr_ff <= ram_wr.addr;
         fwd_data_ff <= ram_wr.data;
      end
      if (exec_map) begin
         rsp_pixel_ff <= map_ready_ff ? bin_data[GRAY_BITS-1:0] : s1_pixel_ff;
         rsp_flag_ff  <= !map_ready_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_pixel_ff;
   assign rsp_not_ready    = rsp_flag_ff;

   hee_bin_ram u_bin_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (exec_clear),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hee_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

`ifndef SYNTHESIS
   a_no_intake_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !accept)
      else $error("item accepted during map build");

   a_walk_write_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN && ram_wr.en) |-> ram_wr.addr == walk_ff)
      else $error("build wrote a bin other than the walk index");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide wait");

   a_map_ready_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(map_ready_ff) |-> $past(state_ff) != ST_RUN)
      else $error("map marked ready without a build walk");

   a_walk_holds_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |=> !$rose(rsp_valid_ff))
      else $error("result produced while building");
`endif

endmodule

@@ rtl/hee_bin_ram.sv @@
// Bin memory: 256 counters, synchronous read, per-entry valid bits.
module hee_bin_ram (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  hee_pkg::ram_wr_type wr,
   input  logic               rd_en,
   input  hee_pkg::addr_type  rd_addr,
   output hee_pkg::count_type rd_data
);
   import hee_pkg::*;

   count_type              mem [BIN_COUNT];
   logic [BIN_COUNT-1:0]   valid_ff;
   count_type              rdata_ff;
   addr_type               raddr_ff;

   // Track which entries hold written data; reset and clear empty all at once
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Store write data
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Register read data and its address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         raddr_ff <= rd_addr;
      end
   end

   // An entry never written since clear reads as zero
   assign rd_data = valid_ff[raddr_ff] ? rdata_ff : '0;

endmodule

@@ rtl/hee_divider.sv @@
// Restoring divider producing an 8-bit quotient, one bit per cycle.
module hee_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  hee_pkg::cdf_type   dividend,
   input  hee_pkg::count_type divisor,
   output logic               done,
   output hee_pkg::gray_type  quotient
);
   import hee_pkg::*;

   logic      busy_ff;
   logic      done_ff;
   step_type  step_ff;
   cdf_type   rem_ff;
   cdf_type   rem_in;
   gray_type  quo_ff;
   count_type div_ff;
   cdf_type   trial;
   logic      take;

   // Compare against the divisor aligned to the current quotient bit
   assign trial  = cdf_type'(div_ff) << step_ff;
   assign take   = (rem_ff >= trial);
   assign rem_in = take ? (rem_ff - trial) : rem_ff;

   // Sequence the steps, quotient bit 7 first
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         // Flag the cycle after the last quotient bit
         done_ff <= busy_ff && !start && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= step_type'(GRAY_BITS - 1);
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   // Hold remainder and quotient bits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[GRAY_BITS-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
